[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this project.
// Depends on nothing; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checks a property on every rising clock edge, during reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[hw/rtl/ssd_pkg.sv]
// Package for the signed shift-subtract divider: default width and the
// command struct between controller and datapath. Depends on nothing.
`default_nettype none

package ssd_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ssd_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/ssd_datapath.sv]
// Datapath of the divider: magnitude load, one restoring step per cycle,
// sign fix-up and the output registers. Depends on ssd_pkg.
`default_nettype none

module ssd_datapath import ssd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire ssd_cmd_t                     cmd,
  input  wire logic signed [DATA_WIDTH-1:0] numerator,
  input  wire logic signed [DATA_WIDTH-1:0] denominator,
  output logic signed [DATA_WIDTH-1:0]      quotient,
  output logic                              saturated
);

  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // The dividend register shifts out dividend bits and shifts in quotient bits.
  logic [DATA_WIDTH-1:0] dvd;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dvs;
  logic                  neg;
  logic                  div_zero;

  logic [DATA_WIDTH-1:0] mag_n;
  logic [DATA_WIDTH-1:0] mag_d;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH+1:0] trial;
  logic                  q_bit;
  logic [DATA_WIDTH-1:0] neg_q;

  always_comb begin
    mag_n  = numerator[DATA_WIDTH-1] ? (~numerator + 1'b1) : numerator;
    mag_d  = denominator[DATA_WIDTH-1] ? (~denominator + 1'b1) : denominator;
    rem_sh = {rem, dvd[DATA_WIDTH-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs};
    q_bit  = ~trial[DATA_WIDTH+1];
    neg_q  = ~dvd + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd      <= mag_n;
      dvs      <= mag_d;
      rem      <= '0;
      neg      <= numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
      div_zero <= (denominator == '0);
    end else if (cmd.step) begin
      rem <= q_bit ? trial[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      dvd <= {dvd[DATA_WIDTH-2:0], q_bit};
    end
    if (cmd.finish) begin
      priority if (div_zero) begin
        quotient  <= MAX_POS;
        saturated <= 1'b1;
      end else if (neg) begin
        quotient  <= neg_q;
        saturated <= 1'b0;
      end else if (dvd[DATA_WIDTH-1]) begin
        quotient  <= MAX_POS;
        saturated <= 1'b1;
      end else begin
        quotient  <= dvd;
        saturated <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ssd_ctrl.sv]
// Controller of the divider: sequences load, the quotient-bit steps and the
// fix-up, and owns the handshakes of both channels. Depends on ssd_pkg.
`default_nettype none

module ssd_ctrl import ssd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ssd_cmd_t  cmd
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;

  always_comb begin
    in_ready   = (state == IDLE);
    cmd.load   = in_valid && (state == IDLE);
    cmd.step   = (state == RUN);
    cmd.finish = (state == FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= RUN;
            count <= CNT_INIT;
          end
        end
        RUN: begin
          if (count == '0) begin
            state <= FINISH;
          end else begin
            count <= count - 1'b1;
          end
        end
        FINISH: begin
          if (cmd.finish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/signed_shift_subtract_divider.sv]
// Signed integer divider, top level: controller and datapath joined by the
// command struct. Depends on ssd_pkg, ssd_ctrl and ssd_datapath.
//
// The input channel takes a beat of numerator and denominator, both signed,
// when in_valid and in_ready are high. The output channel shows a beat of
// quotient (truncated toward zero) and saturated with out_valid, held until
// out_ready is high. A zero divisor, or the most negative dividend divided
// by minus one, gives the largest positive value with saturated set.
// An item goes through a load step, the restoring subtract loop, which
// yields one quotient bit per cycle, and a fix-up step that applies the
// sign and writes the output register. A new item is taken only after the
// last one has left the fix-up step.
// in_ready is high whenever the block is idle, also while a finished beat
// still waits in the output register. If the receiver stalls, the next item
// finishes its loop and holds in the fix-up step until the output register
// frees up. Reset clears the controller and drops out_valid; the datapath
// registers are not reset.
`default_nettype none

module signed_shift_subtract_divider import ssd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] numerator,
  input  wire logic signed [DATA_WIDTH-1:0] denominator,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      quotient,
  output logic                              saturated
);

  ssd_cmd_t cmd;

  ssd_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  ssd_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .numerator  (numerator),
    .denominator(denominator),
    .quotient   (quotient),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

[hw/rtl/ssd_checker.sv]
// Port-level checker for the signed divider and its bind to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssd_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] quotient,
  input wire logic                  saturated
);

  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid)
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_sat_is_max, clk, rst, (out_valid && saturated) |-> (quotient == MAX_POS))
  `ASSERT_CLK(a_out_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(quotient)))

endmodule

bind signed_shift_subtract_divider ssd_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_ssd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .quotient (quotient),
  .saturated(saturated)
);

`default_nettype wire

[tb/testbench.sv]
// Testbench for signed_shift_subtract_divider: drives operand beats, predicts each
// quotient and saturation flag, and checks every output beat in order.
// Depends on ssd_pkg and the signed_shift_subtract_divider RTL.
`timescale 1ns / 100ps

module testbench;
  import ssd_pkg::*;

  localparam int W = DATA_WIDTH_DEF;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam int IDLE_PCT = 23;
  localparam int RANDOM_ITEMS = 1430;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [W-1:0] num;
    logic [W-1:0] den;
    bit drain_first;
  } operand_beat_t;

  typedef struct packed {
    logic [W-1:0] quo;
    logic sat;
  } quotient_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] numerator = '0;
  logic signed [W-1:0] denominator = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] quotient;
  logic saturated;

  operand_beat_t operand_queue[$];
  quotient_beat_t quotient_queue[$];
  int unsigned sent_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  signed_shift_subtract_divider #(.DATA_WIDTH(W)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .numerator(numerator),
    .denominator(denominator),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .quotient(quotient),
    .saturated(saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic quotient_beat_t signed_quotient(logic [W-1:0] n, logic [W-1:0] d);
    quotient_beat_t r;
    logic [W-1:0] mag_n;
    logic [W-1:0] mag_d;
    logic [W-1:0] q;
    logic [W:0] rem;
    logic neg_n;
    logic neg_d;
    r.quo = '0;
    r.sat = 1'b0;
    if (d == '0) begin
      r.quo = MAX_POS;
      r.sat = 1'b1;
    end else if (n != '0) begin
      neg_n = n[W-1];
      neg_d = d[W-1];
      mag_n = neg_n ? -n : n;
      mag_d = neg_d ? -d : d;
      rem = '0;
      q = '0;
      for (int i = W - 1; i >= 0; i--) begin
        rem = {rem[W-1:0], mag_n[i]};
        if (rem >= {1'b0, mag_d}) begin
          rem = rem - {1'b0, mag_d};
          q[i] = 1'b1;
        end
      end
      if (neg_n != neg_d) begin
        r.quo = -q;
      end else if (q > MAX_POS) begin
        r.quo = MAX_POS;
        r.sat = 1'b1;
      end else begin
        r.quo = q;
      end
    end
    return r;
  endfunction

  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: v = v;
      3, 4, 5, 6: v = v >> $urandom_range(0, W - 1);
      7: v = -(v >> $urandom_range(0, W - 1));
      8: v = $urandom_range(0, 16) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0: v = MIN_NEG;
          1: v = MAX_POS;
          2: v = '1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_beat(logic [W-1:0] n, logic [W-1:0] d, bit drain);
    operand_beat_t b;
    b.num = n;
    b.den = d;
    b.drain_first = drain;
    operand_queue.push_back(b);
  endtask

  wire steady = (accepted_count >= 500) && (accepted_count < 760);

  // The beat on the bus is still outstanding while sent_count runs ahead.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && accepted_count < sent_count)) begin
      if (operand_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (operand_queue[0].drain_first && quotient_queue.size() != 0) begin
        in_valid <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
      end else begin
        numerator <= operand_queue[0].num;
        denominator <= operand_queue[0].den;
        in_valid <= 1'b1;
        operand_queue.pop_front();
        sent_count <= sent_count + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    quotient_beat_t exp_beat;
    if (!rst) begin
      if (in_valid && in_ready) begin
        quotient_queue.push_back(signed_quotient(numerator, denominator));
        accepted_count <= accepted_count + 1;
      end
      if (out_valid && out_ready) begin
        if (quotient_queue.size() == 0) begin
          $display("%0t: unexpected output beat quotient=%h saturated=%b",
                   $time, quotient, saturated);
          mismatch_count++;
        end else begin
          exp_beat = quotient_queue.pop_front();
          if (quotient !== exp_beat.quo) begin
            $display("%0t: quotient mismatch expected=%h actual=%h",
                     $time, exp_beat.quo, quotient);
            mismatch_count++;
          end
          if (saturated !== exp_beat.sat) begin
            $display("%0t: saturated mismatch expected=%b actual=%b",
                     $time, exp_beat.sat, saturated);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("signed_shift_subtract_divider test failed");
        $finish;
      end
    end
  end

  initial begin
    add_beat(0, 5, 1'b0);
    add_beat(0, 0, 1'b0);
    add_beat(5, 0, 1'b0);
    add_beat(-5, 0, 1'b0);
    add_beat(MIN_NEG, 0, 1'b0);
    add_beat(MIN_NEG, '1, 1'b0);
    add_beat(MIN_NEG, 1, 1'b0);
    add_beat(MIN_NEG, MIN_NEG, 1'b0);
    add_beat(MAX_POS, MIN_NEG, 1'b0);
    add_beat(MIN_NEG, 2, 1'b0);
    add_beat(MIN_NEG, MAX_POS, 1'b0);
    add_beat(MAX_POS, 1, 1'b0);
    add_beat(MAX_POS, '1, 1'b0);
    add_beat(MAX_POS, MAX_POS, 1'b0);
    add_beat(7, 2, 1'b0);
    add_beat(-7, 2, 1'b0);
    add_beat(7, -2, 1'b0);
    add_beat(-7, -2, 1'b0);
    add_beat(1, MAX_POS, 1'b0);
    add_beat('1, 1, 1'b0);
    add_beat('1, '1, 1'b0);
    add_beat(123456789, -7, 1'b0);
    add_beat(0, '1, 1'b0);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      add_beat(random_operand(), random_operand(), k == 0 || k == 700 || k == 1200);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (operand_queue.size() != 0 || in_valid || quotient_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (80) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("signed_shift_subtract_divider test passed");
    end else begin
      $display("signed_shift_subtract_divider test failed");
    end
    $finish;
  end

endmodule
